// ===== rtl/wrgr_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types.
package wrgr_pkg;

  localparam int DIM_MAX     = 255;
  localparam int DIM_W       = 8;
  localparam int POS_W       = 9;
  localparam int SAMPLE_W    = 16;
  localparam int EPS_W       = 32;
  localparam int RMS_W       = 32;
  localparam int ACC_W       = 60;
  localparam int TERM_W      = 34;
  localparam int N_W         = 3 * DIM_W;
  localparam int QUO_W       = 64;
  localparam int ROOT_W      = QUO_W / 2;
  localparam int SQREM_W     = ROOT_W + 2;
  localparam int PROD_W      = EPS_W + ROOT_W;
  localparam int OUT_SHIFT   = 19;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int DIV_STEPS   = QUO_W;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS    = 2'd3;

  typedef struct packed {
    logic take;
    logic capture;
    logic calc_n;
    logic div_step;
    logic sqrt_step;
    logic mul;
    logic load_out;
  } wrgr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } wrgr_sts_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > DIM_MAX) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

endpackage

// ===== rtl/wrgr_ctrl.sv =====
// Sequencer: accumulate, then divide, square root, scale and hand over the result.
module wrgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  input  wrgr_pkg::wrgr_sts_t sts,
  output wrgr_pkg::wrgr_cmd_t cmd
);
  import wrgr_pkg::*;

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_NXY   = 3'd2;
  localparam logic [2:0] S_NXYZ  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_ACC);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.take      = in_tvalid && in_tready;
    case (state_r)
      S_ACC: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_NXY;
      end
      S_NXY: begin
        cmd.capture = 1'b1;
        state_nxt   = S_NXYZ;
      end
      S_NXYZ: begin
        cmd.calc_n = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/wrgr_dp.sv =====
// Datapath: config registers, weighted square accumulator, divider, root, scaler, output.
module wrgr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [wrgr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wrgr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [wrgr_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [wrgr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tuser,
  input  wrgr_pkg::wrgr_cmd_t                   cmd,
  output wrgr_pkg::wrgr_sts_t                   sts
);
  import wrgr_pkg::*;

  logic [DIM_W-1:0]   grid_x_r, grid_y_r, grid_z_r;
  logic [EPS_W-1:0]   eps_r;
  logic [DIM_W-1:0]   nx, ny, nz;
  logic [POS_W-1:0]   pos_x, pos_y, pos_z;
  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W:0]  mag;
  logic [TERM_W-1:0]  sq, term;
  logic               in_x, in_y, in_z, bx, by, bz;
  logic [1:0]         nb;
  logic [TERM_W-1:0]  term_r;
  logic               term_v_r;
  logic [ACC_W-1:0]   acc_r;
  logic               sat_r;
  logic [ACC_W:0]     sum;
  logic [2*DIM_W-1:0] nxy_r;
  logic [N_W-1:0]     n_r;
  logic [QUO_W-1:0]   q_r;
  logic [N_W-1:0]     rem_r;
  logic [N_W:0]       rem_sh;
  logic [SQREM_W-1:0] sqrem_r, sqrem_sh, trial;
  logic [ROOT_W-1:0]  root_r;
  logic [PROD_W-1:0]  prod_r;
  logic               grid_sat_r;
  logic               out_v_r;
  logic [RMS_W-1:0]   out_data_r;
  logic               out_sat_r;
  logic [RMS_W-1:0]   rms;

  assign pos_x = in_tdata[POS_W-1:0];
  assign pos_y = in_tdata[2*POS_W-1:POS_W];
  assign pos_z = in_tdata[3*POS_W-1:2*POS_W];
  assign raw   = in_tdata[3*POS_W+SAMPLE_W-1:3*POS_W];

  assign nx = eff_dim(grid_x_r);
  assign ny = eff_dim(grid_y_r);
  assign nz = eff_dim(grid_z_r);

  assign in_x = (pos_x != '0) && (pos_x <= ({1'b0, nx} + 1'b1));
  assign in_y = (pos_y != '0) && (pos_y <= ({1'b0, ny} + 1'b1));
  assign in_z = (pos_z != '0) && (pos_z <= ({1'b0, nz} + 1'b1));
  assign bx   = (pos_x == POS_W'(1)) || (pos_x == ({1'b0, nx} + 1'b1));
  assign by   = (pos_y == POS_W'(1)) || (pos_y == ({1'b0, ny} + 1'b1));
  assign bz   = (pos_z == POS_W'(1)) || (pos_z == ({1'b0, nz} + 1'b1));
  assign nb   = {1'b0, bx} + {1'b0, by} + {1'b0, bz};

  assign mag = raw[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, raw}) : {1'b0, raw};
  assign sq  = TERM_W'(mag) * TERM_W'(mag);

  always_comb begin
    case (nb)
      2'd0:    term = sq << 3;
      2'd1:    term = sq << 2;
      2'd2:    term = sq << 1;
      default: term = sq;
    endcase
  end

  assign sum = {1'b0, acc_r} + (ACC_W+1)'(term_r);

  assign rem_sh   = {rem_r, q_r[QUO_W-1]};
  assign sqrem_sh = {sqrem_r[SQREM_W-3:0], q_r[QUO_W-1:QUO_W-2]};
  assign trial    = {root_r, 2'b01};

  assign rms = (prod_r[PROD_W-1:OUT_SHIFT+RMS_W] != '0) ? '1
             : prod_r[OUT_SHIFT+RMS_W-1:OUT_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= DIM_W'(1);
      grid_y_r <= DIM_W'(1);
      grid_z_r <= DIM_W'(1);
      eps_r    <= EPS_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_X: grid_x_r <= cfg_data[DIM_W-1:0];
        REG_GRID_Y: grid_y_r <= cfg_data[DIM_W-1:0];
        REG_GRID_Z: grid_z_r <= cfg_data[DIM_W-1:0];
        REG_EPS:    eps_r    <= cfg_data[EPS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_v_r <= 1'b0;
      acc_r    <= '0;
      sat_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      term_v_r <= cmd.take && in_x && in_y && in_z;
      if (cmd.capture) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else if (term_v_r) begin
        if (sum[ACC_W]) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else begin
          acc_r <= sum[ACC_W-1:0];
        end
      end
      if (cmd.load_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      term_r <= term;
    end
    if (cmd.capture) begin
      nxy_r      <= (2*DIM_W)'(nx) * (2*DIM_W)'(ny);
      q_r        <= {1'b0, acc_r, 3'b000};
      rem_r      <= '0;
      sqrem_r    <= '0;
      root_r     <= '0;
      grid_sat_r <= sat_r;
    end
    if (cmd.calc_n) begin
      n_r <= N_W'(nxy_r) * N_W'(nz);
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, n_r}) begin
        rem_r <= N_W'(rem_sh - {1'b0, n_r});
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[N_W-1:0];
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_step) begin
      q_r <= {q_r[QUO_W-3:0], 2'b00};
      if (sqrem_sh >= trial) begin
        sqrem_r <= sqrem_sh - trial;
        root_r  <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        sqrem_r <= sqrem_sh;
        root_r  <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(eps_r) * PROD_W'(root_r);
    end
    if (cmd.load_out) begin
      out_data_r <= rms;
      out_sat_r  <= grid_sat_r;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_sat_r;
  assign sts.out_busy = out_v_r;

endmodule

// ===== rtl/weighted_rms_grid_reduce.sv =====
// Top level of the weighted RMS grid reduction: sequencer plus datapath.
//
//  channel  direction  payload
//  in_      slave      tdata {pos_x[8:0], pos_y[17:9], pos_z[26:18], sample[42:27]}, tlast
//  out_     master     tdata {rms_value[31:0]}, tuser {saturated}
//  cfg_     slave      index (0..3), data[31:0]
//
// Samples are taken one per cycle while the block accumulates. A transaction with tlast makes
// the block busy: drain, the cell count (x times y, then times z), 64 divider steps, 32 square
// root steps, one multiply and the hand-over to the output register. The output register
// holds a result while new samples stream in; a second result waits while it is full.
// Reset is synchronous; configuration writes are taken in any cycle.
module weighted_rms_grid_reduce (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [wrgr_pkg::IN_TDATA_W-1:0]       in_tdata,  // pos_x, pos_y, pos_z, sample_value
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [wrgr_pkg::OUT_TDATA_W-1:0]      out_tdata, // rms_value
  output logic                                  out_tuser, // saturated
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wrgr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wrgr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wrgr_pkg::*;

  wrgr_cmd_t cmd;
  wrgr_sts_t sts;

  assign cfg_ready = 1'b1;

  wrgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wrgr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for weighted_rms_grid_reduce with a built-in weighted RMS predictor.
module testbench;
  import wrgr_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD = 600;
  localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 64'd1;

  typedef struct packed {
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    z;
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } grid_sample_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic             sat;
  } rms_result_t;

  typedef enum {OUTSIDE, INTERIOR, ON_PLANE} coord_class_t;
  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // pos_x, pos_y, pos_z, sample_value
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;     // rms_value
  logic out_tuser;                       // saturated
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [DIM_W-1:0] dim_x = DIM_W'(1);
  logic [DIM_W-1:0] dim_y = DIM_W'(1);
  logic [DIM_W-1:0] dim_z = DIM_W'(1);
  logic [EPS_W-1:0] eps_q16 = EPS_W'(65536);
  logic [ACC_W-1:0] sq_sum = '0;
  logic sum_clipped = 1'b0;

  grid_sample_t sample_queue[$];
  rms_result_t rms_expected[$];
  grid_sample_t cur_sample;
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  weighted_rms_grid_reduce DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  function automatic coord_class_t coord_class(logic [POS_W-1:0] c, int n);
    if (c == '0 || int'(c) > n + 1) return OUTSIDE;
    if (int'(c) == 1 || int'(c) == n + 1) return ON_PLANE;
    return INTERIOR;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void accumulate_sample(grid_sample_t s);
    int nx;
    int ny;
    int nz;
    int planes;
    coord_class_t cx;
    coord_class_t cy;
    coord_class_t cz;
    logic [16:0] mag;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] cells;
    logic [63:0] quo;
    logic [63:0] scaled;
    rms_result_t r;
    nx = clamp_dim(dim_x);
    ny = clamp_dim(dim_y);
    nz = clamp_dim(dim_z);
    cx = coord_class(s.x, nx);
    cy = coord_class(s.y, ny);
    cz = coord_class(s.z, nz);
    if (cx != OUTSIDE && cy != OUTSIDE && cz != OUTSIDE) begin
      mag = s.value[SAMPLE_W-1] ? (17'h10000 - {1'b0, s.value}) : {1'b0, s.value};
      planes = int'(cx == ON_PLANE) + int'(cy == ON_PLANE) + int'(cz == ON_PLANE);
      term = (64'(mag) * 64'(mag)) << (3 - planes);
      total = 64'(sq_sum) + term;
      if (total > ACC_LIMIT) begin
        total = ACC_LIMIT;
        sum_clipped = 1'b1;
      end
      sq_sum = total[ACC_W-1:0];
    end
    if (s.last) begin
      cells = 64'(nx) * 64'(ny) * 64'(nz);
      quo = (64'(sq_sum) << 3) / cells;
      scaled = (64'(eps_q16) * int_sqrt(quo)) >> OUT_SHIFT;
      r.rms = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      r.sat = sum_clipped;
      rms_expected.push_back(r);
      sq_sum = '0;
      sum_clipped = 1'b0;
    end
  endfunction

  function automatic logic [POS_W-1:0] pick_coord(int n);
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return POS_W'($urandom_range(1, n + 1));
    if (r == 17) return '0;
    if (r == 18 && n + 2 <= 256) return POS_W'(n + 2);
    return POS_W'($urandom_range(0, 256));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_value(bit loud);
    if (loud && $urandom_range(0, 1) == 1) begin
      return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2, 3: return DIM_W'(DIM_MAX);
      4, 5, 6: return DIM_W'($urandom_range(7, 254));
      7: return DIM_W'($urandom());
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic add_sample(int x, int y, int z, logic [SAMPLE_W-1:0] v, bit last);
    grid_sample_t s;
    s.x = POS_W'(x);
    s.y = POS_W'(y);
    s.z = POS_W'(z);
    s.value = v;
    s.last = last;
    sample_queue.push_back(s);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_tvalid || rms_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_X: dim_x = val[DIM_W-1:0];
      REG_GRID_Y: dim_y = val[DIM_W-1:0];
      REG_GRID_Z: dim_z = val[DIM_W-1:0];
      REG_EPS:    eps_q16 = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [DIM_W-1:0] nx, logic [DIM_W-1:0] ny,
                           logic [DIM_W-1:0] nz, logic [EPS_W-1:0] eps);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = $urandom();
    write_reg(REG_GRID_X, {junk[31:8], nx});
    junk = $urandom();
    write_reg(REG_GRID_Y, {junk[31:8], ny});
    junk = $urandom();
    write_reg(REG_GRID_Z, {junk[31:8], nz});
    write_reg(REG_EPS, eps);
    @(negedge clk);
  endtask

  task automatic run_phase(logic [DIM_W-1:0] nx, logic [DIM_W-1:0] ny,
                           logic [DIM_W-1:0] nz, logic [EPS_W-1:0] eps,
                           int n_items, int max_len, bit loud, bit hold);
    int left;
    int len;
    configure(nx, ny, nz, eps);
    if (hold) hold_epoch++;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        add_sample(pick_coord(clamp_dim(nx)), pick_coord(clamp_dim(ny)),
                   pick_coord(clamp_dim(nz)), pick_value(loud), k == len - 1);
      end
      left -= len;
    end
  endtask

  always @(posedge clk) begin : sample_driver
    logic offer;
    offer = in_tvalid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accumulate_sample(cur_sample);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_queue.size() > 0) begin
          cur_sample = sample_queue.pop_front();
          in_tdata <= IN_TDATA_W'({cur_sample.value, cur_sample.z, cur_sample.y,
                                   cur_sample.x});
          in_tlast <= cur_sample.last;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left = $urandom_range(0, 3);
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
    end
    in_tvalid <= offer;
  end

  always @(posedge clk) begin : result_ready
    if (hold_epoch != hold_seen) begin
      hold_seen = hold_epoch;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        default:      out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    rms_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rms_expected.size() == 0) begin
        $error("unexpected result: rms_value %0d saturated %0d", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = rms_expected.pop_front();
        if (out_tdata !== want.rms) begin
          $error("rms_value: expected %0d, got %0d", want.rms, out_tdata);
          err_count++;
        end
        if (out_tuser !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, out_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [EPS_W-1:0] eps_pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_sample(1, 1, 1, 16'h7FFF, 1'b0);
    add_sample(2, 2, 2, 16'h8000, 1'b0);
    add_sample(0, 1, 1, 16'd12345, 1'b0);
    add_sample(1, 3, 1, 16'hFFFF, 1'b0);
    add_sample(256, 256, 256, 16'h7FFF, 1'b0);
    add_sample(2, 1, 2, 16'h0001, 1'b1);
    add_sample(0, 0, 0, 16'h0000, 1'b1);
    add_sample(1, 2, 1, 16'h0000, 1'b1);

    configure(8'd3, 8'd3, 8'd3, 32'h0001_8000);
    add_sample(2, 2, 2, 16'd20000, 1'b0);
    add_sample(1, 2, 2, -16'sd20000, 1'b0);
    add_sample(4, 1, 3, 16'd15000, 1'b0);
    add_sample(1, 4, 1, 16'h8000, 1'b0);
    add_sample(4, 0, 2, 16'h7FFF, 1'b0);
    add_sample(5, 2, 2, 16'h7FFF, 1'b0);
    add_sample(3, 3, 3, 16'h7FFF, 1'b1);
    add_sample(2, 3, 4, -16'sd7, 1'b1);

    configure(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
    add_sample(256, 256, 256, 16'h8000, 1'b0);
    add_sample(128, 200, 1, 16'h7FFF, 1'b0);
    add_sample(255, 255, 255, 16'h8000, 1'b1);

    run_phase(8'd0, 8'd0, 8'd0, 32'd65536, 150, 12, 1'b0, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 250, 30, 1'b0, 1'b0);
    run_phase(8'd1, 8'd1, 8'd1, 32'hFFFF_FFFF, 300, 80, 1'b1, 1'b0);
    run_phase(8'd3, 8'd5, 8'd2, 32'd0, 100, 16, 1'b0, 1'b0);
    run_phase(8'd2, 8'd4, 8'd3, $urandom(), 200, 3, 1'b0, 1'b1);
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: eps_pick = 32'd65536;
        3: eps_pick = 32'hFFFF_FFFF;
        4: eps_pick = '0;
        default: eps_pick = $urandom();
      endcase
      run_phase(pick_dim(), pick_dim(), pick_dim(), eps_pick, 190, 24, p[0], 1'b0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wrgr_pkg.sv
rtl/wrgr_ctrl.sv
rtl/wrgr_dp.sv
rtl/weighted_rms_grid_reduce.sv
tb/testbench.sv
